### rtl/core/pslt_pkg.sv
// Shared constants, types and helper functions for the per-source log throttle table.
package pslt_pkg;

    localparam int MAX_SOURCES = 16;
    localparam int SRC_W       = 4;
    localparam int ADDR_W      = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
    localparam int TIME_W      = 48;
    localparam int CNT_W       = 32;
    localparam int MIN_IV_W    = 16;
    localparam int SYNC_IV_W   = 20;
    localparam int CFG_DATA_W  = 20;
    localparam int CFG_IDX_W   = 1;
    localparam int ENTRY_W     = 2 * TIME_W;

    localparam logic [MIN_IV_W-1:0]  MIN_IV_MAX   = 16'd60000;
    localparam logic [SYNC_IV_W-1:0] SYNC_IV_MAX  = 20'd600000;
    localparam logic [MIN_IV_W-1:0]  MIN_IV_RST   = 16'd1000;
    localparam logic [SYNC_IV_W-1:0] SYNC_IV_RST  = 20'd1000;

    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_QUERY  = 2'd1;
    localparam logic [1:0] REQ_COMMIT = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_IV  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_IV = 1'd1;

    // decision for one word, handed from the evaluator to the state update
    typedef struct packed {
        logic due;
        logic sync_now;
        logic do_commit;
        logic do_clear;
    } pslt_dec_t;

    function automatic logic [MIN_IV_W-1:0] clamp_min_iv(input logic [MIN_IV_W-1:0] v);
        logic [MIN_IV_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = MIN_IV_W'(1);
        end
        else if (v > MIN_IV_MAX)
        begin
            r = MIN_IV_MAX;
        end
        return r;
    endfunction

    function automatic logic [SYNC_IV_W-1:0] clamp_sync_iv(input logic [SYNC_IV_W-1:0] v);
        logic [SYNC_IV_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = SYNC_IV_W'(1);
        end
        else if (v > SYNC_IV_MAX)
        begin
            r = SYNC_IV_MAX;
        end
        return r;
    endfunction

endpackage

### rtl/core/pslt_ram.sv
// Generic single-port-write, registered-read synchronous RAM.
module pslt_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 96,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/pslt_eval.sv
// Decision logic: due test for queries, flush test for ticks, commit and clear strobes.
module pslt_eval (
    input  logic [1:0]                    req_type,
    input  logic                          in_range,
    input  logic [pslt_pkg::TIME_W-1:0]   frame_stamp,
    input  logic [pslt_pkg::TIME_W-1:0]   now_ms,
    input  logic                          entry_valid,
    input  logic [pslt_pkg::TIME_W-1:0]   stored_stamp,
    input  logic [pslt_pkg::TIME_W-1:0]   stored_time,
    input  logic [pslt_pkg::MIN_IV_W-1:0] min_iv,
    input  logic [pslt_pkg::SYNC_IV_W-1:0] sync_iv,
    input  logic                          dirty,
    input  logic [pslt_pkg::TIME_W-1:0]   last_sync,
    output pslt_pkg::pslt_dec_t           dec
);

    logic [pslt_pkg::TIME_W:0] q_diff;
    logic [pslt_pkg::TIME_W:0] t_diff;
    logic                      q_elapsed;
    logic                      t_elapsed;
    logic                      q_ok;

    // borrow out of the 49-bit difference means now is before the earlier time
    assign q_diff = {1'b0, now_ms} - {1'b0, stored_time};
    assign t_diff = {1'b0, now_ms} - {1'b0, last_sync};

    assign q_elapsed = !q_diff[pslt_pkg::TIME_W] &&
        (q_diff[pslt_pkg::TIME_W-1:0] >=
         pslt_pkg::TIME_W'(pslt_pkg::clamp_min_iv(min_iv)));
    assign t_elapsed = !t_diff[pslt_pkg::TIME_W] &&
        (t_diff[pslt_pkg::TIME_W-1:0] >=
         pslt_pkg::TIME_W'(pslt_pkg::clamp_sync_iv(sync_iv)));

    assign q_ok = !entry_valid || ((stored_stamp != frame_stamp) && q_elapsed);

    always_comb
    begin
        dec = '0;
        unique case (req_type)
            pslt_pkg::REQ_TICK:
            begin
                dec.sync_now = dirty && t_elapsed;
            end
            pslt_pkg::REQ_QUERY:
            begin
                dec.due = in_range && (frame_stamp != '0) && q_ok;
            end
            pslt_pkg::REQ_COMMIT:
            begin
                dec.do_commit = in_range;
            end
            pslt_pkg::REQ_CLEAR:
            begin
                dec.do_clear = 1'b1;
            end
            default:
            begin
                dec = '0;
            end
        endcase
    end

endmodule

### rtl/core/per_source_log_throttle_table_top.sv
// Top level of the per-source log throttle table.
// Each request word passes a work stage and the block holds one word at a time: in the
// accept cycle the source's entry (last frame stamp and last write time) is read from
// a 16-entry synchronous RAM; from the work stage the decision is formed and, once the
// result register is free or draining, the entry is written back on a commit and the
// result word is loaded into the output register. Since a new word is only taken once
// the previous one has left the work stage, a read never overlaps the pending write of
// the same entry. Entry valid bits live in flip-flops, so a clear empties the table
// without a pass through the RAM and no clearing pass follows reset. The result
// register lets a new request word be taken while the previous result waits on
// rsp_stall. Configuration writes are registered; out-of-range interval values are
// clamped when used.
module per_source_log_throttle_table_top (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_we,
    input  logic [pslt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pslt_pkg::CFG_DATA_W-1:0]   cfg_data,
    // request channel
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic [1:0]                        req_type,
    input  logic [pslt_pkg::SRC_W-1:0]        source_id,
    input  logic [pslt_pkg::TIME_W-1:0]       frame_stamp,
    input  logic [pslt_pkg::TIME_W-1:0]       now_ms,
    // response channel
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output logic                              due,
    output logic                              sync_now,
    output logic [pslt_pkg::CNT_W-1:0]        entries_logged
);

    // configuration registers
    logic [pslt_pkg::MIN_IV_W-1:0]  min_iv_reg;
    logic [pslt_pkg::SYNC_IV_W-1:0] sync_iv_reg;

    // work stage: the word whose table entry is being read
    logic                           s1_valid_reg;
    logic [1:0]                     s1_req_reg;
    logic [pslt_pkg::ADDR_W-1:0]    s1_addr_reg;
    logic                           s1_in_range_reg;
    logic [pslt_pkg::TIME_W-1:0]    s1_stamp_reg;
    logic [pslt_pkg::TIME_W-1:0]    s1_now_reg;

    // block-wide state
    logic [pslt_pkg::MAX_SOURCES-1:0] valid_reg;
    logic [pslt_pkg::TIME_W-1:0]      last_sync_reg;
    logic                             dirty_reg;
    logic [pslt_pkg::CNT_W-1:0]       count_reg;
    logic [pslt_pkg::CNT_W-1:0]       count_next;

    // result register
    logic                           out_valid_reg;
    logic                           out_due_reg;
    logic                           out_sync_reg;
    logic [pslt_pkg::CNT_W-1:0]     out_count_reg;

    logic                           req_fire;
    logic                           s1_fire;
    logic                           in_range;
    logic [pslt_pkg::ADDR_W-1:0]    req_addr;
    logic [pslt_pkg::ENTRY_W-1:0]   ram_rdata;
    logic [pslt_pkg::ENTRY_W-1:0]   ram_wdata;
    pslt_pkg::pslt_dec_t            dec;

    // one word in flight: stall while the work stage is occupied
    assign req_stall = s1_valid_reg;
    assign req_fire  = req_valid && !req_stall;
    // work stage retires once the result register is free or draining
    assign s1_fire   = s1_valid_reg && !(out_valid_reg && rsp_stall);

    assign in_range  = 32'(source_id) < pslt_pkg::MAX_SOURCES;
    assign req_addr  = pslt_pkg::ADDR_W'(source_id);
    assign ram_wdata = {s1_stamp_reg, s1_now_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_iv_reg  <= pslt_pkg::MIN_IV_RST;
            sync_iv_reg <= pslt_pkg::SYNC_IV_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pslt_pkg::CFG_MIN_IV:
                begin
                    min_iv_reg <= cfg_data[pslt_pkg::MIN_IV_W-1:0];
                end
                pslt_pkg::CFG_SYNC_IV:
                begin
                    sync_iv_reg <= cfg_data[pslt_pkg::SYNC_IV_W-1:0];
                end
                default:
                begin
                    min_iv_reg <= min_iv_reg;
                end
            endcase
        end
    end

    // table RAM: stamp in the upper half, write time in the lower half
    pslt_ram #(
        .DEPTH (pslt_pkg::MAX_SOURCES),
        .WIDTH (pslt_pkg::ENTRY_W),
        .AW    (pslt_pkg::ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (s1_fire && dec.do_commit),
        .waddr (s1_addr_reg),
        .wdata (ram_wdata),
        .re    (req_fire),
        .raddr (req_addr),
        .rdata (ram_rdata)
    );

    pslt_eval u_eval (
        .req_type     (s1_req_reg),
        .in_range     (s1_in_range_reg),
        .frame_stamp  (s1_stamp_reg),
        .now_ms       (s1_now_reg),
        .entry_valid  (valid_reg[s1_addr_reg]),
        .stored_stamp (ram_rdata[pslt_pkg::ENTRY_W-1:pslt_pkg::TIME_W]),
        .stored_time  (ram_rdata[pslt_pkg::TIME_W-1:0]),
        .min_iv       (min_iv_reg),
        .sync_iv      (sync_iv_reg),
        .dirty        (dirty_reg),
        .last_sync    (last_sync_reg),
        .dec          (dec)
    );

    // work stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // work stage payload
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_req_reg      <= req_type;
            s1_addr_reg     <= req_addr;
            s1_in_range_reg <= in_range;
            s1_stamp_reg    <= frame_stamp;
            s1_now_reg      <= now_ms;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (dec.do_clear)
        begin
            count_next = '0;
        end
        else if (dec.do_commit)
        begin
            count_next = count_reg + pslt_pkg::CNT_W'(1);
        end
    end

    // block-wide state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            last_sync_reg <= '0;
            dirty_reg     <= 1'b0;
            count_reg     <= '0;
        end
        else if (s1_fire)
        begin
            count_reg <= count_next;
            if (dec.do_clear)
            begin
                valid_reg <= '0;
            end
            else if (dec.do_commit)
            begin
                valid_reg[s1_addr_reg] <= 1'b1;
                dirty_reg              <= 1'b1;
            end
            else if (dec.sync_now)
            begin
                last_sync_reg <= s1_now_reg;
                dirty_reg     <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_due_reg   <= dec.due;
            out_sync_reg  <= dec.sync_now;
            out_count_reg <= count_next;
        end
    end

    assign rsp_valid      = out_valid_reg;
    assign due            = out_due_reg;
    assign sync_now       = out_sync_reg;
    assign entries_logged = out_count_reg;

    // a word in the work stage either stays or moves into the result register
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |=> (s1_valid_reg || out_valid_reg))
        else $error("word lost from work stage");

    // a clear leaves the counter at zero
    a_clear_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && dec.do_clear) |=> (count_reg == '0))
        else $error("counter not zero after clear");

    // a flush decision clears the dirty flag
    a_sync_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && dec.sync_now) |=> !dirty_reg)
        else $error("dirty flag survived flush");

    // a commit leaves the block dirty
    a_commit_dirty: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && dec.do_commit) |=> dirty_reg)
        else $error("commit did not set dirty");

    // due and sync_now belong to different request types
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_due_reg && out_sync_reg))
        else $error("due and sync_now both set");

endmodule
